>>> sv/arrd_pkg.sv
// Package for the autoscaling round-robin dispatcher: sizes, op codes, limits.
`timescale 1ns / 1ps
package arrd_pkg;
    localparam int NUM_WORKERS = 16;
    localparam int ID_W        = $clog2(NUM_WORKERS);
    localparam int CNT_W       = 16;
    localparam int TOTAL_W     = 20;
    localparam int POOL_W      = 5;

    localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic [2:0] OP_START      = 3'd0;
    localparam logic [2:0] OP_DISPATCH   = 3'd1;
    localparam logic [2:0] OP_REGISTER   = 3'd2;
    localparam logic [2:0] OP_UNREGISTER = 3'd3;
    localparam logic [2:0] OP_RESIZE     = 3'd4;

    localparam logic [2:0] REG_MIN_WORKERS  = 3'd0;
    localparam logic [2:0] REG_MAX_WORKERS  = 3'd1;
    localparam logic [2:0] REG_HIGH_CONN    = 3'd2;
    localparam logic [2:0] REG_HIGH_PENDING = 3'd3;
    localparam logic [2:0] REG_IDLE_LIMIT   = 3'd4;

    typedef logic [ID_W-1:0] worker_id_t;
endpackage

>>> sv/autoscaling_round_robin_dispatcher.sv
// Autoscaling round-robin dispatcher: top level with its sequencer.
//
// Usage:
//  Input channel (in_valid/in_stall) takes one operation item: start,
//  dispatch, register, unregister or resize tick. Output channel
//  (out_valid/out_stall) gives exactly one result item per input item.
//  Configuration is written through cfg_we/cfg_index/cfg_data while idle.
//  Sequence: register, unregister and unused codes are decoded and then
//  complete; dispatch forms the threshold products in decode, then decides;
//  start adds one worker per step until the pool reaches the minimum or no
//  id is free; a resize tick that is not acted on completes after decode,
//  otherwise an idle scan runs over the active slots, then each retired
//  worker is searched for slot by slot and removed if found.
//  A single shared compare/update path and a one-slot-per-cycle scan
//  do this work. One item is in work at a time; in_stall is high
//  from acceptance until the result register is free again.
//  A stalled result is held in the output register; the next item is taken
//  only once it has gone.
//  Reset empties the pool, clears the connection and idle counts and loads register defaults.
`timescale 1ns / 1ps
module autoscaling_round_robin_dispatcher
    import arrd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          op,
    input  logic [3:0]          worker_id,
    input  logic                on_base,
    input  logic [19:0]         pending_total,
    input  logic [15:0]         idle_work_mask,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [3:0]          chosen_worker,
    output logic                chose_base,
    output logic                worker_added,
    output logic [4:0]          recycled_count,
    output logic [4:0]          active_workers,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_START   = 4'd2;
    localparam logic [3:0] S_DISP    = 4'd3;
    localparam logic [3:0] S_SCAN    = 4'd4;
    localparam logic [3:0] S_RMSEL   = 4'd5;
    localparam logic [3:0] S_RMFIND  = 4'd6;
    localparam logic [3:0] S_RMDO    = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    logic [3:0] state_reg, state_next;

    logic [4:0]  min_reg, max_reg;
    logic [15:0] hconn_reg, hpend_reg;
    logic [7:0]  ilimit_reg;

    logic [2:0]  op_reg;
    logic [3:0]  wid_reg;
    logic        base_sel_reg;
    logic [19:0] pend_reg;
    logic [15:0] mask_reg;

    logic [3:0]  slot_table [NUM_WORKERS];
    logic [CNT_W-1:0] conn_count [NUM_WORKERS];
    logic [7:0]  idle_rounds [NUM_WORKERS];
    logic [NUM_WORKERS-1:0] in_use_reg;
    logic [POOL_W-1:0] active_reg;
    logic [3:0]  next_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [CNT_W-1:0] base_conn_reg;

    logic [3:0]  mark_list [NUM_WORKERS];   // ids marked for retirement, in slot order
    logic [POOL_W-1:0] mark_n_reg, mark_rd_reg;
    logic [POOL_W-1:0] idx_reg;             // scan / search index
    logic [3:0]  rm_id_reg;
    logic [36:0] prod_conn_reg, prod_pend_reg;

    logic [3:0]  r_chosen;
    logic        r_base, r_added;
    logic [4:0]  r_recycled;
    logic        ovalid_reg;

    // lowest free id
    logic [3:0] free_id;
    logic       free_ok;
    always_comb
    begin
        free_id = '0;
        free_ok = 1'b0;
        for (int i = NUM_WORKERS - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_id = 4'(i);
                free_ok = 1'b1;
            end
        end
    end

    // next marked id, in slot order
    logic [3:0] mark_id;
    logic       mark_any;
    assign mark_any = mark_rd_reg < mark_n_reg;
    assign mark_id  = mark_list[mark_rd_reg[3:0]];

    logic [4:0] floor_n, ceil_n;
    assign floor_n = (min_reg > 5'(NUM_WORKERS)) ? 5'(NUM_WORKERS) : min_reg;
    assign ceil_n  = (max_reg > 5'(NUM_WORKERS)) ? 5'(NUM_WORKERS) : max_reg;

    logic can_add;
    assign can_add = free_ok && (active_reg < 5'(NUM_WORKERS));

    assign in_stall = (state_reg != S_IDLE) || ovalid_reg;
    assign out_valid = ovalid_reg;
    assign chosen_worker = r_chosen;
    assign chose_base = r_base;
    assign worker_added = r_added;
    assign recycled_count = r_recycled;
    assign active_workers = active_reg;

    logic [3:0] scan_id;
    logic [3:0] last_id;
    assign scan_id = slot_table[idx_reg[3:0]];
    assign last_id = slot_table[4'(active_reg - 5'd1)];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_valid && !in_stall) state_next = S_DECODE;
            S_DECODE:
            begin
                case (op_reg)
                    OP_START:    state_next = S_START;
                    OP_DISPATCH: state_next = S_DISP;
                    OP_RESIZE:
                        state_next = (max_reg > min_reg && active_reg > min_reg)
                                     ? S_SCAN : S_DONE;
                    default:     state_next = S_DONE;
                endcase
            end
            S_START:
                if (!(active_reg < floor_n && can_add)) state_next = S_DONE;
            S_DISP:   state_next = S_DONE;
            S_SCAN:   if (idx_reg + 5'd1 >= active_reg) state_next = S_RMSEL;
            S_RMSEL:
                state_next = (mark_any && active_reg > min_reg) ? S_RMFIND : S_DONE;
            S_RMFIND:
                if (idx_reg >= active_reg) state_next = S_RMSEL;
                else if (scan_id == rm_id_reg) state_next = S_RMDO;
            S_RMDO:   state_next = S_RMSEL;
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            min_reg       <= 5'd0;
            max_reg       <= 5'd16;
            hconn_reg     <= 16'd64;
            hpend_reg     <= 16'd64;
            ilimit_reg    <= 8'd3;
            in_use_reg    <= '0;
            active_reg    <= '0;
            next_reg      <= '0;
            total_reg     <= '0;
            base_conn_reg <= '0;
            ovalid_reg    <= 1'b0;
            for (int i = 0; i < NUM_WORKERS; i++)
            begin
                conn_count[i]  <= '0;
                idle_rounds[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MIN_WORKERS:  min_reg    <= cfg_data[4:0];
                    REG_MAX_WORKERS:  max_reg    <= cfg_data[4:0];
                    REG_HIGH_CONN:    hconn_reg  <= cfg_data;
                    REG_HIGH_PENDING: hpend_reg  <= cfg_data;
                    REG_IDLE_LIMIT:   ilimit_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (ovalid_reg && !out_stall)
                ovalid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        op_reg       <= op;
                        wid_reg      <= worker_id;
                        base_sel_reg <= on_base;
                        pend_reg     <= pending_total;
                        mask_reg     <= idle_work_mask;
                    end
                end
                S_DECODE:
                begin
                    r_chosen   <= '0;
                    r_base     <= 1'b0;
                    r_added    <= 1'b0;
                    r_recycled <= '0;
                    idx_reg    <= '0;
                    mark_n_reg  <= '0;
                    mark_rd_reg <= '0;
                    prod_conn_reg <= 37'(active_reg) * 37'(hconn_reg);
                    prod_pend_reg <= 37'(active_reg) * 37'(hpend_reg);
                    if (op_reg == OP_REGISTER)
                    begin
                        if (base_sel_reg)
                        begin
                            if (base_conn_reg < CNT_MAX && total_reg < TOTAL_MAX)
                            begin
                                base_conn_reg <= base_conn_reg + 1'b1;
                                total_reg     <= total_reg + 1'b1;
                            end
                        end
                        else if (in_use_reg[wid_reg])
                        begin
                            if (conn_count[wid_reg] < CNT_MAX && total_reg < TOTAL_MAX)
                            begin
                                conn_count[wid_reg] <= conn_count[wid_reg] + 1'b1;
                                total_reg           <= total_reg + 1'b1;
                            end
                            idle_rounds[wid_reg] <= '0;
                        end
                    end
                    else if (op_reg == OP_UNREGISTER)
                    begin
                        if (base_sel_reg)
                        begin
                            if (base_conn_reg != '0)
                            begin
                                base_conn_reg <= base_conn_reg - 1'b1;
                                if (total_reg != '0) total_reg <= total_reg - 1'b1;
                            end
                        end
                        else if (in_use_reg[wid_reg] && conn_count[wid_reg] != '0)
                        begin
                            conn_count[wid_reg] <= conn_count[wid_reg] - 1'b1;
                            if (total_reg != '0) total_reg <= total_reg - 1'b1;
                        end
                    end
                end
                S_START:
                begin
                    if (active_reg < floor_n && can_add)
                    begin
                        in_use_reg[free_id]            <= 1'b1;
                        conn_count[free_id]            <= '0;
                        idle_rounds[free_id]           <= '0;
                        slot_table[active_reg[3:0]]    <= free_id;
                        active_reg                     <= active_reg + 1'b1;
                        r_added                        <= 1'b1;
                    end
                end
                S_DISP:
                begin : disp
                    logic       grow;
                    logic [4:0] n;
                    logic [3:0] sel, ptr;
                    grow = (active_reg < ceil_n) && can_add &&
                           (active_reg == '0 ||
                            37'(total_reg) > prod_conn_reg ||
                            37'(pend_reg) > prod_pend_reg);
                    n   = grow ? active_reg + 1'b1 : active_reg;
                    ptr = (5'(next_reg) >= n) ? 4'd0 : next_reg;
                    sel = (grow && ptr == active_reg[3:0]) ? free_id
                                                           : slot_table[ptr];
                    if (grow)
                    begin
                        in_use_reg[free_id]         <= 1'b1;
                        conn_count[free_id]         <= '0;
                        idle_rounds[free_id]        <= '0;
                        slot_table[active_reg[3:0]] <= free_id;
                        active_reg                  <= n;
                        r_added                     <= 1'b1;
                    end
                    if (n == '0)
                        r_base <= 1'b1;
                    else
                    begin
                        r_chosen <= sel;
                        next_reg <= (5'(ptr) + 5'd1 >= n) ? 4'd0 : ptr + 4'd1;
                    end
                end
                S_SCAN:
                begin : scan
                    logic [7:0] inc;
                    inc = (idle_rounds[scan_id] == 8'hFF) ? 8'hFF
                                                         : idle_rounds[scan_id] + 8'd1;
                    if (conn_count[scan_id] == '0 && mask_reg[scan_id])
                    begin
                        idle_rounds[scan_id] <= inc;
                        if (inc >= ilimit_reg)
                        begin
                            mark_list[mark_n_reg[3:0]] <= scan_id;
                            mark_n_reg <= mark_n_reg + 5'd1;
                        end
                    end
                    else
                        idle_rounds[scan_id] <= '0;
                    idx_reg <= idx_reg + 5'd1;
                end
                S_RMSEL:
                begin
                    rm_id_reg <= mark_id;
                    idx_reg <= '0;
                    // a marked id is counted even if it is not found, and then it is not removed
                    if (mark_any && active_reg > min_reg)
                    begin
                        mark_rd_reg <= mark_rd_reg + 5'd1;
                        r_recycled  <= r_recycled + 5'd1;
                    end
                end
                S_RMFIND:
                begin
                    if (idx_reg < active_reg && scan_id != rm_id_reg)
                        idx_reg <= idx_reg + 5'd1;
                end
                S_RMDO:
                begin
                    slot_table[idx_reg[3:0]] <= last_id;
                    active_reg <= active_reg - 5'd1;
                    in_use_reg[rm_id_reg] <= 1'b0;
                    total_reg <= (total_reg >= 20'(conn_count[rm_id_reg]))
                                 ? total_reg - 20'(conn_count[rm_id_reg]) : '0;
                    conn_count[rm_id_reg]  <= '0;
                    idle_rounds[rm_id_reg] <= '0;
                    if (5'(next_reg) >= active_reg - 5'd1) next_reg <= '0;
                end
                S_DONE:   ovalid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

endmodule
